FILE: sv/sorted_table_binary_search_defines.svh
// Assertion macros used by the sorted table search RTL.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset
`define STS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset
`define STS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sts_pkg.sv
// Types, constants and codes of the sorted table search block.
package sts_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int VAL_W       = 32;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_ENTRY_COUNT = 3'd0;

  // Operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Engine states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_DONE
  } state_e;

  // One input item as seen by the engine
  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] key;
  } cmd_t;

  // One search result
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } res_t;

endpackage

FILE: sv/sts_engine.sv
// Table memory and binary search sequencer.
`include "sorted_table_binary_search_defines.svh"

module sts_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  sts_pkg::cmd_t             cmd_i,
  input  logic [sts_pkg::CNT_W-1:0] entry_count_i,
  output logic                      idle_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output sts_pkg::res_t             res_o
);

  sts_pkg::state_e state_q, state_d;
  logic [sts_pkg::CNT_W-1:0] lo_q, lo_d, end_q, end_d;
  logic [sts_pkg::IDX_W-1:0] mid_q, mid_d;
  logic signed [sts_pkg::VAL_W-1:0] key_q, key_d;
  sts_pkg::res_t res_q, res_d;

  // Table storage, one write and one registered read per cycle
  logic signed [sts_pkg::VAL_W-1:0] mem [sts_pkg::TABLE_DEPTH];
  logic signed [sts_pkg::VAL_W-1:0] rdata_q;
  logic                      wr_en, rd_en;
  logic [sts_pkg::IDX_W-1:0] rd_addr;

  logic [sts_pkg::CNT_W-1:0] n_eff, mid_first, lo_nx, end_nx, mid_nx;
  logic                      hit, key_lt, more;

  // Saturate the count at the table depth
  assign n_eff = (entry_count_i > sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH))
                 ? sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH) : entry_count_i;
  assign mid_first = (n_eff - sts_pkg::CNT_W'(1)) >> 1;

  // Probe compare and narrowed bounds
  assign hit    = (key_q == rdata_q);
  assign key_lt = (key_q < rdata_q);
  assign lo_nx  = key_lt ? lo_q : sts_pkg::CNT_W'(mid_q) + sts_pkg::CNT_W'(1);
  assign end_nx = key_lt ? sts_pkg::CNT_W'(mid_q) : end_q;
  assign more   = (lo_nx < end_nx);
  assign mid_nx = lo_nx + ((end_nx - lo_nx - sts_pkg::CNT_W'(1)) >> 1);

  // Memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cmd_i.index] <= cmd_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sts_pkg::ST_IDLE: begin
        if (start_i && cmd_i.op == sts_pkg::OP_SEARCH) begin
          state_d = (n_eff == '0) ? sts_pkg::ST_DONE : sts_pkg::ST_PROBE;
        end
      end
      sts_pkg::ST_PROBE: begin
        if (hit || !more) begin
          state_d = sts_pkg::ST_DONE;
        end
      end
      sts_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = sts_pkg::ST_IDLE;
        end
      end
      default: state_d = sts_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    lo_d    = lo_q;
    end_d   = end_q;
    mid_d   = mid_q;
    key_d   = key_q;
    res_d   = res_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = mid_first[sts_pkg::IDX_W-1:0];
    case (state_q)
      sts_pkg::ST_IDLE: begin
        if (start_i && cmd_i.op == sts_pkg::OP_WRITE) begin
          wr_en = 1'b1;
        end
        if (start_i && cmd_i.op == sts_pkg::OP_SEARCH) begin
          lo_d    = '0;
          end_d   = n_eff;
          mid_d   = mid_first[sts_pkg::IDX_W-1:0];
          key_d   = cmd_i.key;
          res_d   = '0;
          rd_en   = (n_eff != '0);
          rd_addr = mid_first[sts_pkg::IDX_W-1:0];
        end
      end
      sts_pkg::ST_PROBE: begin
        if (hit) begin
          res_d.found    = 1'b1;
          res_d.position = mid_q;
        end else begin
          lo_d    = lo_nx;
          end_d   = end_nx;
          mid_d   = mid_nx[sts_pkg::IDX_W-1:0];
          rd_en   = more;
          rd_addr = mid_nx[sts_pkg::IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    end_q <= end_d;
    mid_q <= mid_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  assign idle_o      = (state_q == sts_pkg::ST_IDLE);
  assign res_valid_o = (state_q == sts_pkg::ST_DONE);
  assign res_o       = res_q;

  // Checks
  `STS_ASSERT_IMP(a_bounds_open, state_q == sts_pkg::ST_PROBE, lo_q < end_q, "probe with crossed bounds")
  `STS_ASSERT_IMP(a_mid_in_span, state_q == sts_pkg::ST_PROBE, (sts_pkg::CNT_W'(mid_q) >= lo_q) && (sts_pkg::CNT_W'(mid_q) < end_q), "probe index outside span")
  `STS_ASSERT_IMP(a_end_in_table, state_q == sts_pkg::ST_PROBE, end_q <= sts_pkg::CNT_W'(sts_pkg::TABLE_DEPTH), "search span beyond table")
  `STS_ASSERT_IMP(a_miss_pos_zero, res_valid_o && !res_q.found, res_q.position == '0, "miss with nonzero position")
  `STS_ASSERT_NXT(a_write_no_result, idle_o && start_i && cmd_i.op == sts_pkg::OP_WRITE, idle_o, "write item left idle")

endmodule

FILE: sv/sorted_table_binary_search.sv
// Top level of the sorted table binary search block.
// Holds a table of 1024 signed 32-bit entries, kept sorted ascending by software.
// Input stream: tuser carries the operation (write entry or search), tdata the
// entry index, entry value and search key. A write item stores one entry, one
// item per cycle while no search is in flight, and gives no result. A search
// item searches entries 0 to entry_count-1 (capped at 1024) and gives one result:
// tuser = found flag, tdata = matching position (0 on a miss).
// Each probe reads the table memory through its registered read port; a search
// takes k probes (k at most 11 for a full table), then its result passes from
// the engine's done state into the output register, and the next item is taken
// once the engine is idle again. One search is in flight at a time.
// entry_count is set over the APB port at address 0; the user writes it only
// while idle, which the block itself does not enforce. Reset clears entry_count
// and the handshake state; table contents are undefined until written. The
// output register holds a result while the receiver stalls; the block keeps
// accepting writes meanwhile, and a further search completes and waits until that register frees.
module sorted_table_binary_search (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sts_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sts_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sts_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [79:0]                    s_axis_tdata,  // entry_index, entry_value, search_key
  input  logic                           s_axis_tuser,  // operation
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // position
  output logic                           m_axis_tuser   // found
);

  logic [sts_pkg::CNT_W-1:0] count_q;
  logic                      cfg_we;
  sts_pkg::cmd_t             cmd;
  sts_pkg::res_t             eng_res, out_q;
  logic                      eng_idle, eng_res_valid, eng_res_ready, out_valid_q;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == sts_pkg::REG_ENTRY_COUNT);
  assign prdata = (paddr == sts_pkg::REG_ENTRY_COUNT)
                  ? sts_pkg::APB_DATA_W'(count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we) begin
      count_q <= pwdata[sts_pkg::CNT_W-1:0];
    end
  end

  // Unpack the input item
  assign cmd.op    = s_axis_tuser;
  assign cmd.index = s_axis_tdata[sts_pkg::IDX_W-1:0];
  assign cmd.value = s_axis_tdata[41:10];
  assign cmd.key   = s_axis_tdata[73:42];

  assign s_axis_tready = eng_idle;

  sts_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (s_axis_tvalid && eng_idle),
    .cmd_i        (cmd),
    .entry_count_i(count_q),
    .idle_o       (eng_idle),
    .res_valid_o  (eng_res_valid),
    .res_ready_i  (eng_res_ready),
    .res_o        (eng_res)
  );

  // Output register
  assign eng_res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_res_ready) begin
      out_valid_q <= eng_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_res_valid && eng_res_ready) begin
      out_q <= eng_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tdata  = 16'(out_q.position);

endmodule

FILE: tb/sv/sorted_table_binary_search_tb.sv
// Self-checking stream testbench for the sorted table binary search block.
`timescale 1ns / 100ps

module sorted_table_binary_search_tb;
  import sts_pkg::*;

  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

  // Clock, reset and block inputs, all known from time zero
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [79:0]           s_axis_tdata  = '0;  // entry_index, entry_value, search_key
  logic                  s_axis_tuser  = 1'b0;  // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;  // position
  logic                  m_axis_tuser;  // found

  // Shadow copy of the table and the entry count
  logic signed [VAL_W-1:0] shadow_table [TABLE_DEPTH];
  logic [CNT_W-1:0]        shadow_count = '0;
  res_t                    pending_results [$];

  int mismatch_count = 0;
  int send_gap_pct   = 12;
  int recv_gap_pct   = 75;
  int stall_request  = 0;

  sorted_table_binary_search DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("sorted_table_binary_search: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Binary search over the shadow table, with the count saturated at the depth
  function automatic res_t predict_search(input logic signed [VAL_W-1:0] key);
    res_t r;
    int   lo;
    int   hi;
    int   mid;
    int   n;
    n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    r.found    = 1'b0;
    r.position = '0;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (key == shadow_table[IDX_W'(mid)]) begin
        r.found    = 1'b1;
        r.position = IDX_W'(mid);
        break;
      end
      if (key < shadow_table[IDX_W'(mid)]) hi = mid - 1;
      else lo = mid + 1;
    end
    return r;
  endfunction

  // Key mix: mostly table hits and near misses, some extremes and noise
  function automatic logic [VAL_W-1:0] pick_key();
    int n;
    int r;
    logic [VAL_W-1:0] v;
    n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    r = $urandom_range(0, 99);
    if (n > 0 && r < 70) begin
      v = shadow_table[IDX_W'($urandom_range(0, n - 1))];
      if (r >= 50) v = ($urandom_range(0, 1) != 0) ? v + 1 : v - 1;
      return v;
    end
    if (r < 85) return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
    return $urandom;
  endfunction

  // Offer one item, wait for acceptance, then update the shadow state
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic [VAL_W-1:0] key);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, key, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_WRITE) shadow_table[idx] = val;
    else pending_results.push_back(predict_search(key));
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    send_item(OP_WRITE, idx, val, $urandom);
  endtask

  task automatic search_for(input logic [VAL_W-1:0] key);
    send_item(OP_SEARCH, IDX_W'($urandom), $urandom, key);
  endtask

  // Stop offering, wait for every result, then let the block settle
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Write entry_count over APB while idle, then read it back
  task automatic set_entry_count(input logic [CNT_W-1:0] v);
    drain_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ENTRY_COUNT;
    pwdata  <= APB_DATA_W'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_count = v;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(v)) report_mismatch("entry_count read", prdata, APB_DATA_W'(v));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Load entries 0..n-1 ascending (duplicates allowed), or in random order
  task automatic load_prefix(input int n, input bit shuffled);
    longint acc;
    int     step_max;
    acc = longint'($signed($urandom_range(0, 1) != 0 ? VAL_MIN : $urandom));
    step_max = ($urandom_range(0, 1) != 0) ? 3 : (1 << 24);
    for (int i = 0; i < n; i++) begin
      if (acc > longint'(2147483647)) acc = longint'(2147483647);
      write_entry(IDX_W'(i), shuffled ? $urandom : VAL_W'(acc));
      acc += longint'($urandom_range(0, step_max));
    end
  endtask

  // Empty table: every search misses
  task automatic test_empty_table();
    set_entry_count('0);
    search_for(VAL_MIN);
    search_for(VAL_MAX);
  endtask

  // Value extremes, hits at both ends, misses between, single entry, unsorted table
  task automatic test_directed_cases();
    write_entry(10'd0, VAL_MIN);
    write_entry(10'd1, -32'sd1);
    write_entry(10'd2, 32'sd0);
    write_entry(10'd3, 32'sd1);
    write_entry(10'd4, 32'sd1000);
    write_entry(10'd5, VAL_MAX);
    write_entry(10'd1023, $urandom);
    set_entry_count(11'd6);
    search_for(VAL_MIN);
    search_for(VAL_MAX);
    search_for(32'sd0);
    search_for(-32'sd1);
    search_for(32'sd1000);
    search_for(32'sd2);
    search_for(VAL_MIN + 1);
    set_entry_count(11'd1);
    search_for(VAL_MIN);
    search_for(32'sd5);
    // An out-of-order entry that the probe sequence never reaches
    write_entry(10'd4, -32'sd7);
    set_entry_count(11'd6);
    search_for(-32'sd7);
  endtask

  // Full table, long receiver stall, sender pause, saturated count
  task automatic test_full_table();
    longint acc;
    acc = longint'($signed(VAL_MIN)) + longint'($urandom_range(1, 1000));
    write_entry(10'd0, VAL_MIN);
    for (int i = 1; i < TABLE_DEPTH - 1; i++) begin
      if (acc > longint'(2147483647)) acc = longint'(2147483647);
      write_entry(IDX_W'(i), VAL_W'(acc));
      acc += longint'($urandom_range(1, 4_000_000));
    end
    write_entry(IDX_W'(TABLE_DEPTH - 1), VAL_MAX);
    set_entry_count(11'd1024);
    repeat (30) search_for(pick_key());
    // Receiver holds off while searches keep coming, so the input stalls
    stall_request = 400;
    repeat (40) search_for(pick_key());
    // Sender pauses until every result is back
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) search_for(pick_key());
    set_entry_count(11'd2047);
    repeat (20) search_for(pick_key());
    set_entry_count(11'd1023);
    repeat (10) search_for(pick_key());
  endtask

  // Random phases: load a prefix (counts up to 64), set the count, mix searches with writes
  task automatic test_random_traffic(input int quota);
    int sent;
    int r;
    int c;
    int n_items;
    sent = 0;
    while (sent < quota) begin
      r = $urandom_range(0, 99);
      if (r < 5) c = 0;
      else if (r < 10) c = 1;
      else if (r < 75) c = $urandom_range(2, 16);
      else if (r < 90) c = $urandom_range(17, 64);
      else if (r < 95) c = TABLE_DEPTH;
      else c = $urandom_range(TABLE_DEPTH + 1, 2047);
      if (c <= 64) begin
        load_prefix(c, $urandom_range(0, 99) < 15);
        sent += c;
      end
      set_entry_count(CNT_W'(c));
      n_items = $urandom_range(10, 40);
      repeat (n_items) begin
        if ($urandom_range(0, 99) < 75) search_for(pick_key());
        else if (c < TABLE_DEPTH && $urandom_range(0, 99) < 80)
          write_entry(IDX_W'($urandom_range(c, TABLE_DEPTH - 1)), $urandom);
        else write_entry(IDX_W'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  // Receiver: random stalls, plus a counted hold-off on request
  always @(negedge clk_i) begin
    static int stall_left = 0;
    if (stall_request > 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // Result checker: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", 32'({m_axis_tuser, m_axis_tdata}), '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.found)
          report_mismatch("found", 32'(m_axis_tuser), 32'(want.found));
        if (m_axis_tdata !== 16'(want.position))
          report_mismatch("position", 32'(m_axis_tdata), 32'(want.position));
      end
    end
  end

  // Test sequence
  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) shadow_table[IDX_W'(i)] = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_directed_cases();
    test_full_table();
    test_random_traffic(250);
    send_gap_pct = 75;
    recv_gap_pct = 12;
    test_random_traffic(250);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_traffic(250);
    drain_results();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("sorted_table_binary_search: match");
    end else begin
      $display("sorted_table_binary_search: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/sts_pkg.sv
sv/sts_engine.sv
sv/sorted_table_binary_search.sv
tb/sv/sorted_table_binary_search_tb.sv
